// File: hdl/ddmcf_pkg.sv
`timescale 1ns / 1ps

package ddmcf_pkg;

    localparam int unsigned ELAPSED_WIDTH_DEF = 32;

    localparam logic [7:0] CFG_MIN_PERIOD   = 8'd0;
    localparam logic [7:0] CFG_TIMEOUT      = 8'd1;
    localparam logic [7:0] CFG_CHECK_PERIOD = 8'd2;
    localparam logic [7:0] CFG_DEADZONE     = 8'd3;

    localparam logic [15:0] MIN_PERIOD_RST   = 16'd100;
    localparam logic [15:0] TIMEOUT_RST      = 16'd500;
    localparam logic [15:0] CHECK_PERIOD_RST = 16'd500;
    localparam logic [6:0]  DEADZONE_RST     = 7'd9;

    localparam logic [6:0] PCT_MAX = 7'd99;

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_CR   = 8'h0D;

    localparam logic [3:0] IDX_EQ_L   = 4'd0;
    localparam logic [3:0] IDX_L      = 4'd1;
    localparam logic [3:0] IDX_L_DIR  = 4'd2;
    localparam logic [3:0] IDX_L_TENS = 4'd3;
    localparam logic [3:0] IDX_L_ONES = 4'd4;
    localparam logic [3:0] IDX_EQ_R   = 4'd5;
    localparam logic [3:0] IDX_R      = 4'd6;
    localparam logic [3:0] IDX_R_DIR  = 4'd7;
    localparam logic [3:0] IDX_R_TENS = 4'd8;
    localparam logic [3:0] IDX_R_ONES = 4'd9;
    localparam logic [3:0] IDX_CR     = 4'd10;

    // Rounded-up percent ceil(|d| * 99 / 32768), saturated at 99.
    function automatic logic [6:0] pct_ceil(input logic [16:0] d);
        logic [16:0] mag;
        logic [23:0] sum;
        logic [8:0]  c;
        mag = d[16] ? (~d + 17'd1) : d;
        sum = {7'd0, mag} * 24'd99 + 24'd32767;
        c = sum[23:15];
        pct_ceil = (c > {2'b00, PCT_MAX}) ? PCT_MAX : c[6:0];
    endfunction

    // floor(x / 99) for x up to 99 * 99, by reciprocal multiplication.
    function automatic logic [6:0] div99(input logic [13:0] x);
        logic [23:0] p;
        p = {10'd0, x} * 24'd662;
        div99 = p[22:16];
    endfunction

    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        tens_of = p[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] t);
        logic [6:0] r;
        r = v - ({3'd0, t} * 7'd10);
        ones_of = r[3:0];
    endfunction

endpackage

// File: hdl/diff_drive_motor_command_framer_unit.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+--------------------------------
// input     | in        | i_valid / o_stall       | i_opcode, i_throttle, i_yaw_rate
// result    | out       | o_valid / i_stall       | o_frame_byte, o_frame_last
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A beat is taken every cycle while the input register drains; beats that raise no frame,
// ticks or commands, are never held in the input register by a stall.
// A frame is 11 result beats, one per cycle unless stalled; frame-raising beats wait in the
// input register until the single frame register that feeds the output register is free.
// The first byte passes the input, frame and output registers; the digits come from a
// three-stage percent pipeline that finishes before the first digit byte is selected.
// Reset is synchronous and active low and loads the register defaults; no clearing pass.
// A stalled output holds its byte and backs up into the input stall only for frame beats.

module diff_drive_motor_command_framer_unit #(
    parameter int unsigned ELAPSED_WIDTH = ddmcf_pkg::ELAPSED_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic signed [15:0] i_throttle,
    input  logic signed [15:0] i_yaw_rate,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_frame_byte,
    output logic               o_frame_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import ddmcf_pkg::*;

    logic [15:0] r_min_period;
    logic [15:0] r_timeout;
    logic [15:0] r_check_period;
    logic [6:0]  r_deadzone;

    logic               r_in_valid;
    logic               r_in_op;
    logic signed [15:0] r_in_thr;
    logic signed [15:0] r_in_yaw;

    logic [ELAPSED_WIDTH-1:0] r_elapsed;
    logic [ELAPSED_WIDTH-1:0] n_elapsed;
    logic [15:0]              r_phase;
    logic [15:0]              n_phase;

    logic       r_frm_valid;
    logic [3:0] r_frm_idx;
    logic       r_frm_lneg;
    logic       r_frm_rneg;
    logic [6:0] r_frm_lc;
    logic [6:0] r_frm_rc;

    logic [13:0] r_lprod;
    logic [13:0] r_rprod;
    logic [6:0]  r_lpct;
    logic [6:0]  r_rpct;
    logic [3:0]  r_ltens;
    logic [3:0]  r_lones;
    logic [3:0]  r_rtens;
    logic [3:0]  r_rones;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic        in_acc;
    logic        a_emit;
    logic        a_go;
    logic        out_adv;
    logic        frm_free;
    logic [16:0] a_ld;
    logic [16:0] a_rd;
    logic [15:0] a_period;
    logic [6:0]  dz_span;
    logic        dz_over;
    logic [7:0]  sel_byte;

    assign o_cfg_ready = 1'b1;
    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_last = r_out_last;

    assign out_adv  = !r_out_valid || !i_stall;
    assign frm_free = !r_frm_valid || (out_adv && r_frm_idx == IDX_CR);
    assign a_go     = r_in_valid && (!a_emit || frm_free);
    assign o_stall  = r_in_valid && !a_go;
    assign in_acc   = i_valid && !o_stall;

    assign dz_over = r_deadzone > PCT_MAX;
    assign dz_span = dz_over ? 7'd0 : (PCT_MAX - r_deadzone);

    always_comb begin
        a_period  = (r_check_period == 16'd0) ? 16'd1 : r_check_period;
        a_emit    = 1'b0;
        a_ld      = 17'd0;
        a_rd      = 17'd0;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        if (r_in_op == OP_CMD) begin
            a_emit    = r_elapsed >= {{(ELAPSED_WIDTH-16){1'b0}}, r_min_period};
            a_ld      = {r_in_thr[15], r_in_thr} - {r_in_yaw[15], r_in_yaw};
            a_rd      = {r_in_thr[15], r_in_thr} + {r_in_yaw[15], r_in_yaw};
            n_elapsed = a_emit ? '0 : r_elapsed;
        end else begin
            if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + ELAPSED_WIDTH'(1);
            end
            n_phase = r_phase + 16'd1;
            if (n_phase >= a_period) begin
                n_phase = 16'd0;
                a_emit  = n_elapsed > {{(ELAPSED_WIDTH-16){1'b0}}, r_timeout};
            end
        end
    end

    always_comb begin
        case (r_frm_idx)
            IDX_EQ_L:   sel_byte = CH_EQ;
            IDX_L:      sel_byte = CH_L;
            IDX_L_DIR:  sel_byte = r_frm_lneg ? CH_B : CH_F;
            IDX_L_TENS: sel_byte = CH_ZERO + {4'd0, r_ltens};
            IDX_L_ONES: sel_byte = CH_ZERO + {4'd0, r_lones};
            IDX_EQ_R:   sel_byte = CH_EQ;
            IDX_R:      sel_byte = CH_R;
            IDX_R_DIR:  sel_byte = r_frm_rneg ? CH_B : CH_F;
            IDX_R_TENS: sel_byte = CH_ZERO + {4'd0, r_rtens};
            IDX_R_ONES: sel_byte = CH_ZERO + {4'd0, r_rones};
            IDX_CR:     sel_byte = CH_CR;
            default:    sel_byte = CH_CR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period   <= MIN_PERIOD_RST;
            r_timeout      <= TIMEOUT_RST;
            r_check_period <= CHECK_PERIOD_RST;
            r_deadzone     <= DEADZONE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_PERIOD:   r_min_period   <= i_cfg_data;
                CFG_TIMEOUT:      r_timeout      <= i_cfg_data;
                CFG_CHECK_PERIOD: r_check_period <= i_cfg_data;
                CFG_DEADZONE:     r_deadzone     <= i_cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (a_go) begin
            r_in_valid <= 1'b0;
        end
        if (in_acc) begin
            r_in_op  <= i_opcode;
            r_in_thr <= i_throttle;
            r_in_yaw <= i_yaw_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_phase   <= 16'd0;
        end else if (a_go) begin
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
            r_frm_idx   <= IDX_EQ_L;
        end else if (a_go && a_emit) begin
            r_frm_valid <= 1'b1;
            r_frm_idx   <= IDX_EQ_L;
        end else if (r_frm_valid && out_adv) begin
            if (r_frm_idx == IDX_CR) begin
                r_frm_valid <= 1'b0;
                r_frm_idx   <= IDX_EQ_L;
            end else begin
                r_frm_idx <= r_frm_idx + 4'd1;
            end
        end
        if (a_go && a_emit) begin
            r_frm_lneg <= a_ld[16];
            r_frm_rneg <= a_rd[16];
            r_frm_lc   <= pct_ceil(a_ld);
            r_frm_rc   <= pct_ceil(a_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lprod <= {7'd0, r_frm_lc} * {7'd0, dz_span};
        r_rprod <= {7'd0, r_frm_rc} * {7'd0, dz_span};
        r_lpct  <= (dz_over || r_frm_lc < r_deadzone) ? 7'd0 : r_deadzone + div99(r_lprod);
        r_rpct  <= (dz_over || r_frm_rc < r_deadzone) ? 7'd0 : r_deadzone + div99(r_rprod);
        r_ltens <= tens_of(r_lpct);
        r_lones <= ones_of(r_lpct, tens_of(r_lpct));
        r_rtens <= tens_of(r_rpct);
        r_rones <= ones_of(r_rpct, tens_of(r_rpct));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_frm_valid;
        end
        if (out_adv && r_frm_valid) begin
            r_out_byte <= sel_byte;
            r_out_last <= r_frm_idx == IDX_CR;
        end
    end

    a_frm_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frm_valid |-> r_frm_idx <= IDX_CR)
        else $error("frame byte index out of range");

    a_cmd_clears_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && r_in_op == OP_CMD && a_emit) |=> r_elapsed == '0)
        else $error("accepted command did not clear the idle counter");

    a_stall_only_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && a_emit && r_frm_valid))
        else $error("input stalled without a pending frame");

    a_last_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> r_out_byte == CH_CR)
        else $error("frame end flag on a byte other than carriage return");

endmodule
